// File: sv/bdda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_pkg
// Types, constants and calendar helpers shared by the business-day date adder.
// ----------------------------------------------------------------------------
package bdda_pkg;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 16;
	localparam int WD_W   = 3;
	localparam int SUM_W  = 15;
	localparam int MUL_A_W = 15;
	localparam int MUL_K_W = 18;
	localparam int PROD_W = MUL_A_W + MUL_K_W;
	localparam int M400_W = 9;
	localparam int M100_W = 7;

	localparam int MAX_YEAR_DEF = 9999;

	// reciprocals: x / 25 = (x * K25) >> 18 for x < 4096, x / 7 = (x * K7) >> 20 for x < 32768
	localparam logic [MUL_K_W-1:0] K25     = MUL_K_W'(10486);
	localparam int                 SH25    = 18;
	localparam logic [MUL_K_W-1:0] K7      = MUL_K_W'(149797);
	localparam int                 SH7     = 20;
	localparam int                 Q100_W  = 8;
	localparam int                 Q400_W  = 6;
	localparam int                 Q7_W    = 13;

	localparam logic [MON_W-1:0]  MON_FEB = MON_W'(2);
	localparam logic [MON_W-1:0]  MON_DEC = MON_W'(12);
	localparam logic [DAY_W-1:0]  DAY_LAST_DEC = DAY_W'(31);
	localparam logic [WD_W-1:0]   WD_SAT  = WD_W'(5);
	localparam logic [WD_W-1:0]   WD_SUN  = WD_W'(6);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_Y400,
		ST_MOD,
		ST_YY400,
		ST_SUM,
		ST_MUL7,
		ST_WDAY,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_Y400,
		OP_SET_MOD,
		OP_MUL_YY400,
		OP_SUM,
		OP_MUL7,
		OP_WDAY,
		OP_STEP,
		OP_OVF,
		OP_WRITE
	} op_t;

	typedef struct packed {
		logic bad;
		logic days_zero;
		logic at_end;
	} status_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
			4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
			default:                                    len = '0;
		endcase
		return len;
	endfunction

	// floor(31 * mm / 12) for the shifted month index
	function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] mm);
		logic [DAY_W-1:0] off;
		unique case (mm)
			4'd1:    off = DAY_W'(2);
			4'd2:    off = DAY_W'(5);
			4'd3:    off = DAY_W'(7);
			4'd4:    off = DAY_W'(10);
			4'd5:    off = DAY_W'(12);
			4'd6:    off = DAY_W'(15);
			4'd7:    off = DAY_W'(18);
			4'd8:    off = DAY_W'(20);
			4'd9:    off = DAY_W'(23);
			4'd10:   off = DAY_W'(25);
			4'd11:   off = DAY_W'(28);
			4'd12:   off = DAY_W'(31);
			default: off = '0;
		endcase
		return off;
	endfunction

endpackage

// File: sv/business_day_date_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// business_day_date_adder
// Adds a count of Monday-to-Friday days to a Gregorian date.
// ----------------------------------------------------------------------------
// One item at a time. After an item is accepted, the setup states (Y400, MOD,
// YY400, SUM, MUL7, WDAY) compute the start weekday through one shared
// reciprocal multiplier, then the date stepper walks one calendar day per
// cycle until the working-day count is used up or the last day of MAX_YEAR
// is reached, and the result goes to the output register once that register
// is empty or being read. An invalid start date skips the walk. The next item
// is accepted as soon as the result is in the output register, even while it
// waits there.
// ----------------------------------------------------------------------------
module business_day_date_adder #(
	parameter int MAX_YEAR = bdda_pkg::MAX_YEAR_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // start_day, start_month, start_year, working_days
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // end_day, end_month, end_year, end_weekday
	output logic [1:0]  m_tuser    // bad_date, year_overflow
);

	bdda_pkg::op_t     op;
	bdda_pkg::status_t status;

	logic [bdda_pkg::DAY_W-1:0]  end_day;
	logic [bdda_pkg::MON_W-1:0]  end_month;
	logic [bdda_pkg::YEAR_W-1:0] end_year;
	logic [bdda_pkg::WD_W-1:0]   end_weekday;
	logic                        bad_date;
	logic                        year_overflow;

	bdda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.op       (op)
	);

	bdda_dp #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.status        (status),
		.start_day     (s_tdata[4:0]),
		.start_month   (s_tdata[8:5]),
		.start_year    (s_tdata[22:9]),
		.working_days  (s_tdata[38:23]),
		.end_day       (end_day),
		.end_month     (end_month),
		.end_year      (end_year),
		.end_weekday   (end_weekday),
		.bad_date      (bad_date),
		.year_overflow (year_overflow)
	);

	assign m_tdata = {6'b0, end_weekday, end_year, end_month, end_day};
	assign m_tuser = {year_overflow, bad_date};

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	a_bad_no_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[25:23] == 3'd0) && !m_tuser[1])
		else $error("invalid date result carries weekday or overflow");

	a_ovf_on_last_day: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata[4:0] == 5'd31) && (m_tdata[8:5] == 4'd12)
			&& (m_tdata[22:9] == bdda_pkg::YEAR_W'(MAX_YEAR)))
		else $error("overflow result not on the last day of the last year");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:23] != 3'd7))
		else $error("weekday out of range");
`endif

endmodule

// File: sv/bdda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_ctrl
// Sequencer: weekday setup steps, day walk loop and output handoff.
// ----------------------------------------------------------------------------
module bdda_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  bdda_pkg::status_t  status,
	output bdda_pkg::op_t      op
);

	bdda_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdda_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == bdda_pkg::OP_WRITE) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdda_pkg::ST_IDLE:  if (s_tvalid) state_d = bdda_pkg::ST_Y400;
			bdda_pkg::ST_Y400:  state_d = bdda_pkg::ST_MOD;
			bdda_pkg::ST_MOD:   state_d = bdda_pkg::ST_YY400;
			bdda_pkg::ST_YY400: state_d = bdda_pkg::ST_SUM;
			bdda_pkg::ST_SUM:   state_d = bdda_pkg::ST_MUL7;
			bdda_pkg::ST_MUL7:  state_d = bdda_pkg::ST_WDAY;
			bdda_pkg::ST_WDAY:  state_d = status.bad ? bdda_pkg::ST_DONE : bdda_pkg::ST_WALK;
			bdda_pkg::ST_WALK:  if (status.days_zero || status.at_end) state_d = bdda_pkg::ST_DONE;
			bdda_pkg::ST_DONE:  if (!out_valid_q || m_tready) state_d = bdda_pkg::ST_IDLE;
			default:            state_d = bdda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		op = bdda_pkg::OP_NONE;
		unique case (state_q)
			bdda_pkg::ST_IDLE:  if (s_tvalid) op = bdda_pkg::OP_LOAD;
			bdda_pkg::ST_Y400:  op = bdda_pkg::OP_MUL_Y400;
			bdda_pkg::ST_MOD:   op = bdda_pkg::OP_SET_MOD;
			bdda_pkg::ST_YY400: op = bdda_pkg::OP_MUL_YY400;
			bdda_pkg::ST_SUM:   op = bdda_pkg::OP_SUM;
			bdda_pkg::ST_MUL7:  op = bdda_pkg::OP_MUL7;
			bdda_pkg::ST_WDAY:  op = bdda_pkg::OP_WDAY;
			bdda_pkg::ST_WALK: begin
				priority if (status.days_zero) op = bdda_pkg::OP_NONE;
				else if (status.at_end)        op = bdda_pkg::OP_OVF;
				else                           op = bdda_pkg::OP_STEP;
			end
			bdda_pkg::ST_DONE:  if (!out_valid_q || m_tready) op = bdda_pkg::OP_WRITE;
			default:            op = bdda_pkg::OP_NONE;
		endcase
	end

	assign s_tready = (state_q == bdda_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

// File: sv/bdda_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_dp
// Datapath: date registers, shared reciprocal multiplier, weekday, output.
// ----------------------------------------------------------------------------
module bdda_dp #(
	parameter int MAX_YEAR = bdda_pkg::MAX_YEAR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bdda_pkg::op_t                 op,
	output bdda_pkg::status_t             status,
	input  logic [bdda_pkg::DAY_W-1:0]    start_day,
	input  logic [bdda_pkg::MON_W-1:0]    start_month,
	input  logic [bdda_pkg::YEAR_W-1:0]   start_year,
	input  logic [bdda_pkg::CNT_W-1:0]    working_days,
	output logic [bdda_pkg::DAY_W-1:0]    end_day,
	output logic [bdda_pkg::MON_W-1:0]    end_month,
	output logic [bdda_pkg::YEAR_W-1:0]   end_year,
	output logic [bdda_pkg::WD_W-1:0]     end_weekday,
	output logic                          bad_date,
	output logic                          year_overflow
);

	localparam logic [bdda_pkg::YEAR_W-1:0] MAX_Y = bdda_pkg::YEAR_W'(MAX_YEAR);

	logic [bdda_pkg::DAY_W-1:0]  walk_day_q;
	logic [bdda_pkg::MON_W-1:0]  walk_month_q;
	logic [bdda_pkg::YEAR_W-1:0] walk_year_q;
	logic [bdda_pkg::CNT_W-1:0]  days_left_q;

	logic [bdda_pkg::M400_W-1:0] mod400_q;
	logic [bdda_pkg::M100_W-1:0] mod100_q;
	logic [bdda_pkg::PROD_W-1:0] prod_q;
	logic [bdda_pkg::Q100_W-1:0] c100_q;
	logic [bdda_pkg::SUM_W-1:0]  sum_q;
	logic [bdda_pkg::WD_W-1:0]   wd_q;
	logic                        bad_q;
	logic                        ovf_q;

	logic [bdda_pkg::DAY_W-1:0]  out_day_q;
	logic [bdda_pkg::MON_W-1:0]  out_month_q;
	logic [bdda_pkg::YEAR_W-1:0] out_year_q;
	logic [bdda_pkg::WD_W-1:0]   out_wd_q;
	logic                        out_bad_q;
	logic                        out_ovf_q;

	logic                         jan_feb;
	logic [bdda_pkg::YEAR_W-1:0]  yy;
	logic [bdda_pkg::MON_W-1:0]   mm;
	logic                         leap;
	logic [bdda_pkg::DAY_W-1:0]   mlen;
	logic [bdda_pkg::MUL_A_W-1:0] mul_a;
	logic [bdda_pkg::MUL_K_W-1:0] mul_k;
	logic [bdda_pkg::Q400_W-1:0]  q400;
	logic [bdda_pkg::YEAR_W-1:0]  mod400_full;
	logic [bdda_pkg::M100_W-1:0]  mod100_d;
	logic [bdda_pkg::SUM_W-1:0]   sum_d;
	logic [bdda_pkg::Q7_W-1:0]    q7;
	logic [bdda_pkg::SUM_W-1:0]   rem7;
	logic [bdda_pkg::WD_W-1:0]    raw_wd;
	logic                         bad_d;

	assign jan_feb = (walk_month_q <= bdda_pkg::MON_FEB);
	assign yy      = walk_year_q - bdda_pkg::YEAR_W'(jan_feb);
	assign mm      = jan_feb ? walk_month_q + bdda_pkg::MON_W'(10)
	                         : walk_month_q - bdda_pkg::MON_W'(2);
	assign leap    = (mod400_q == '0) || ((walk_year_q[1:0] == 2'b00) && (mod100_q != '0));
	assign mlen    = bdda_pkg::month_len(walk_month_q, leap);

	always_comb begin
		mul_a = '0;
		mul_k = '0;
		unique case (op)
			bdda_pkg::OP_MUL_Y400: begin
				mul_a = bdda_pkg::MUL_A_W'(walk_year_q >> 4);
				mul_k = bdda_pkg::K25;
			end
			bdda_pkg::OP_SET_MOD: begin
				mul_a = bdda_pkg::MUL_A_W'(yy >> 2);
				mul_k = bdda_pkg::K25;
			end
			bdda_pkg::OP_MUL_YY400: begin
				mul_a = bdda_pkg::MUL_A_W'(yy >> 4);
				mul_k = bdda_pkg::K25;
			end
			bdda_pkg::OP_MUL7: begin
				mul_a = sum_q;
				mul_k = bdda_pkg::K7;
			end
			default: begin
				mul_a = '0;
				mul_k = '0;
			end
		endcase
	end

	assign q400        = prod_q[bdda_pkg::SH25 +: bdda_pkg::Q400_W];
	assign mod400_full = walk_year_q - bdda_pkg::YEAR_W'(q400) * bdda_pkg::YEAR_W'(400);

	always_comb begin
		priority if (mod400_q >= bdda_pkg::M400_W'(300))
			mod100_d = bdda_pkg::M100_W'(mod400_q - bdda_pkg::M400_W'(300));
		else if (mod400_q >= bdda_pkg::M400_W'(200))
			mod100_d = bdda_pkg::M100_W'(mod400_q - bdda_pkg::M400_W'(200));
		else if (mod400_q >= bdda_pkg::M400_W'(100))
			mod100_d = bdda_pkg::M100_W'(mod400_q - bdda_pkg::M400_W'(100));
		else
			mod100_d = bdda_pkg::M100_W'(mod400_q);
	end

	assign sum_d = bdda_pkg::SUM_W'(walk_day_q) + bdda_pkg::SUM_W'(yy)
	             + bdda_pkg::SUM_W'(yy >> 2) - bdda_pkg::SUM_W'(c100_q)
	             + bdda_pkg::SUM_W'(q400) + bdda_pkg::SUM_W'(bdda_pkg::month_offset(mm));

	assign bad_d = (walk_month_q == '0) || (walk_month_q > bdda_pkg::MON_DEC)
	            || (walk_year_q == '0) || (walk_year_q > MAX_Y)
	            || (walk_day_q == '0) || (walk_day_q > mlen);

	assign q7     = prod_q[bdda_pkg::SH7 +: bdda_pkg::Q7_W];
	assign rem7   = sum_q - bdda_pkg::SUM_W'(q7) * bdda_pkg::SUM_W'(7);
	assign raw_wd = rem7[bdda_pkg::WD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_day_q   <= bdda_pkg::DAY_W'(1);
			walk_month_q <= bdda_pkg::MON_W'(1);
			walk_year_q  <= bdda_pkg::YEAR_W'(1);
			days_left_q  <= '0;
		end else begin
			unique case (op)
				bdda_pkg::OP_LOAD: begin
					walk_day_q   <= start_day;
					walk_month_q <= start_month;
					walk_year_q  <= start_year;
					days_left_q  <= working_days;
				end
				bdda_pkg::OP_STEP: begin
					if (wd_q < bdda_pkg::WD_SAT) begin
						days_left_q <= days_left_q - bdda_pkg::CNT_W'(1);
					end
					if (walk_day_q >= mlen) begin
						walk_day_q <= bdda_pkg::DAY_W'(1);
						if (walk_month_q == bdda_pkg::MON_DEC) begin
							walk_month_q <= bdda_pkg::MON_W'(1);
							walk_year_q  <= walk_year_q + bdda_pkg::YEAR_W'(1);
						end else begin
							walk_month_q <= walk_month_q + bdda_pkg::MON_W'(1);
						end
					end else begin
						walk_day_q <= walk_day_q + bdda_pkg::DAY_W'(1);
					end
				end
				default: begin
					walk_day_q <= walk_day_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_k != '0) begin
			prod_q <= bdda_pkg::PROD_W'(mul_a) * bdda_pkg::PROD_W'(mul_k);
		end
		unique case (op)
			bdda_pkg::OP_LOAD: begin
				ovf_q <= 1'b0;
			end
			bdda_pkg::OP_SET_MOD: begin
				mod400_q <= mod400_full[bdda_pkg::M400_W-1:0];
			end
			bdda_pkg::OP_MUL_YY400: begin
				c100_q   <= prod_q[bdda_pkg::SH25 +: bdda_pkg::Q100_W];
				mod100_q <= mod100_d;
			end
			bdda_pkg::OP_SUM: begin
				sum_q <= sum_d;
				bad_q <= bad_d;
			end
			bdda_pkg::OP_WDAY: begin
				wd_q <= (raw_wd == '0) ? bdda_pkg::WD_SUN : raw_wd - bdda_pkg::WD_W'(1);
			end
			bdda_pkg::OP_STEP: begin
				wd_q <= (wd_q == bdda_pkg::WD_SUN) ? '0 : wd_q + bdda_pkg::WD_W'(1);
				if ((walk_day_q >= mlen) && (walk_month_q == bdda_pkg::MON_DEC)) begin
					mod400_q <= (mod400_q == bdda_pkg::M400_W'(399)) ? '0
					          : mod400_q + bdda_pkg::M400_W'(1);
					mod100_q <= (mod100_q == bdda_pkg::M100_W'(99)) ? '0
					          : mod100_q + bdda_pkg::M100_W'(1);
				end
			end
			bdda_pkg::OP_OVF: begin
				ovf_q <= 1'b1;
			end
			bdda_pkg::OP_WRITE: begin
				out_day_q   <= walk_day_q;
				out_month_q <= walk_month_q;
				out_year_q  <= walk_year_q;
				out_wd_q    <= bad_q ? '0 : wd_q;
				out_bad_q   <= bad_q;
				out_ovf_q   <= ovf_q;
			end
			default: begin
				ovf_q <= ovf_q;
			end
		endcase
	end

	assign status.bad       = bad_q;
	assign status.days_zero = (days_left_q == '0);
	assign status.at_end    = (walk_day_q == bdda_pkg::DAY_LAST_DEC)
	                       && (walk_month_q == bdda_pkg::MON_DEC) && (walk_year_q == MAX_Y);

	assign end_day       = out_day_q;
	assign end_month     = out_month_q;
	assign end_year      = out_year_q;
	assign end_weekday   = out_wd_q;
	assign bad_date      = out_bad_q;
	assign year_overflow = out_ovf_q;

endmodule

// File: tb/tb_business_day_date_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_business_day_date_adder
// Self-checking bench for the business-day date adder. A short table of directed
// dates (calendar edges, invalid dates, weekend starts, the last year) runs
// first, then about 1900 random dates in three idling phases. Each result is
// checked field by field against a calendar walk, or a typed row's table entry.
// ----------------------------------------------------------------------------
module tb_business_day_date_adder;
	import bdda_pkg::*;

	localparam int unsigned LAST_YEAR      = MAX_YEAR_DEF;
	localparam int unsigned YEAR_FIELD_MAX = 16383;
	localparam int unsigned WD_MON         = 0;
	localparam int          DIR_N          = 25;
	localparam int          RAND_PER_PHASE = 630;
	localparam int          DRAIN_CYCLES   = 64;
	// the longest legal item walks with nothing accepted
	localparam int          STALL_LIMIT    = 400000;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [CNT_W-1:0]  count;
	} date_in_t;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [WD_W-1:0]   weekday;
		logic              bad;
		logic              ovf;
	} date_out_t;

	typedef struct packed {
		date_in_t  stim;
		logic      typed;
		date_out_t want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{'{5'd1, 4'd1, 14'd1, 16'd0}, 1'b1, '{5'd1, 4'd1, 14'd1, 3'd0, 1'b0, 1'b0}},
		'{'{5'd31, 4'd12, 14'd9999, 16'd0}, 1'b0, '0},
		'{'{5'd0, 4'd1, 14'd2024, 16'd5}, 1'b1, '{5'd0, 4'd1, 14'd2024, 3'd0, 1'b1, 1'b0}},
		'{'{5'd15, 4'd0, 14'd2024, 16'd7}, 1'b1, '{5'd15, 4'd0, 14'd2024, 3'd0, 1'b1, 1'b0}},
		'{'{5'd15, 4'd13, 14'd2024, 16'd7}, 1'b1, '{5'd15, 4'd13, 14'd2024, 3'd0, 1'b1, 1'b0}},
		'{'{5'd31, 4'd15, 14'd16383, 16'd65535}, 1'b1,
			'{5'd31, 4'd15, 14'd16383, 3'd0, 1'b1, 1'b0}},
		'{'{5'd10, 4'd6, 14'd0, 16'd3}, 1'b1, '{5'd10, 4'd6, 14'd0, 3'd0, 1'b1, 1'b0}},
		'{'{5'd10, 4'd6, 14'd10000, 16'd3}, 1'b1, '{5'd10, 4'd6, 14'd10000, 3'd0, 1'b1, 1'b0}},
		'{'{5'd29, 4'd2, 14'd1900, 16'd1}, 1'b1, '{5'd29, 4'd2, 14'd1900, 3'd0, 1'b1, 1'b0}},
		'{'{5'd29, 4'd2, 14'd2100, 16'd1}, 1'b1, '{5'd29, 4'd2, 14'd2100, 3'd0, 1'b1, 1'b0}},
		'{'{5'd31, 4'd4, 14'd2023, 16'd1}, 1'b1, '{5'd31, 4'd4, 14'd2023, 3'd0, 1'b1, 1'b0}},
		'{'{5'd30, 4'd2, 14'd2000, 16'd1}, 1'b1, '{5'd30, 4'd2, 14'd2000, 3'd0, 1'b1, 1'b0}},
		'{'{5'd29, 4'd2, 14'd2000, 16'd1}, 1'b0, '0},
		'{'{5'd29, 4'd2, 14'd2024, 16'd4}, 1'b0, '0},
		'{'{5'd1, 4'd6, 14'd2024, 16'd1}, 1'b0, '0},
		'{'{5'd2, 4'd6, 14'd2024, 16'd1}, 1'b0, '0},
		'{'{5'd31, 4'd5, 14'd2024, 16'd1}, 1'b0, '0},
		'{'{5'd31, 4'd1, 14'd2023, 16'd3}, 1'b0, '0},
		'{'{5'd28, 4'd2, 14'd2023, 16'd2}, 1'b0, '0},
		'{'{5'd28, 4'd2, 14'd1900, 16'd1}, 1'b0, '0},
		'{'{5'd31, 4'd12, 14'd1999, 16'd2}, 1'b0, '0},
		'{'{5'd31, 4'd12, 14'd9999, 16'd1}, 1'b0, '0},
		'{'{5'd31, 4'd12, 14'd9998, 16'd260}, 1'b0, '0},
		'{'{5'd1, 4'd1, 14'd9999, 16'd65535}, 1'b0, '0},
		'{'{5'd1, 4'd1, 14'd2000, 16'd65535}, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	logic        in_taken = 1'b0;
	int          src_idle_pct = 38;
	int          sink_idle_pct = 51;
	int          stall_cycles = 0;
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          bad_seen = 0;
	int          ovf_seen = 0;

	int unsigned cal_day = 1;
	int unsigned cal_month = 1;
	int unsigned cal_year = 1;
	int unsigned days_to_go = 0;

	date_out_t   end_date_q [$];

	business_day_date_adder #(
		.MAX_YEAR(LAST_YEAR)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial forever #10 clk = ~clk;

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		logic leap;
		leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			MON_FEB:               return leap ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic date_out_t predict_end_date(input date_in_t it);
		date_out_t   r;
		int unsigned a;
		int unsigned yy;
		int unsigned mm;
		int unsigned wd;
		logic        bad;
		logic        ovf;
		cal_day = it.day;
		cal_month = it.month;
		cal_year = it.year;
		days_to_go = it.count;
		wd = WD_MON;
		ovf = 1'b0;
		bad = cal_month < 1 || cal_month > MON_DEC || cal_year < 1 || cal_year > LAST_YEAR ||
			cal_day < 1 || cal_day > days_in_month(cal_month, cal_year);
		if (!bad) begin
			a = (14 - cal_month) / 12;
			yy = cal_year - a;
			mm = cal_month + 12 * a - 2;
			wd = (cal_day + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
			wd = (wd == 0) ? WD_SUN : wd - 1;
			while (days_to_go != 0) begin
				if (cal_day == DAY_LAST_DEC && cal_month == MON_DEC && cal_year == LAST_YEAR) begin
					ovf = 1'b1;
					break;
				end
				if (wd < WD_SAT)
					days_to_go--;
				if (cal_day >= days_in_month(cal_month, cal_year)) begin
					cal_day = 1;
					if (cal_month == MON_DEC) begin
						cal_month = 1;
						cal_year++;
					end else begin
						cal_month++;
					end
				end else begin
					cal_day++;
				end
				wd = (wd == WD_SUN) ? WD_MON : wd + 1;
			end
		end
		r.day = DAY_W'(cal_day);
		r.month = MON_W'(cal_month);
		r.year = YEAR_W'(cal_year);
		r.weekday = WD_W'(wd);
		r.bad = bad;
		r.ovf = ovf;
		return r;
	endfunction

	function automatic date_in_t random_date(input int unsigned ylo, input int unsigned yhi);
		date_in_t    it;
		int unsigned m;
		int unsigned y;
		y = $urandom_range(yhi, ylo);
		m = $urandom_range(MON_DEC, 1);
		it.year = YEAR_W'(y);
		it.month = MON_W'(m);
		it.day = DAY_W'($urandom_range(days_in_month(m, y), 1));
		it.count = '0;
		return it;
	endfunction

	function automatic date_in_t next_random_item();
		date_in_t    it;
		int unsigned short_mon [5] = '{2, 4, 6, 9, 11};
		int unsigned pick;
		int unsigned len;
		int unsigned y;
		pick = $urandom_range(99);
		if (pick < 52) begin
			it = random_date(1, LAST_YEAR);
			it.count = CNT_W'($urandom_range(40));
		end else if (pick < 62) begin
			it = random_date(1, LAST_YEAR);
			it.count = CNT_W'($urandom_range(400));
		end else if (pick < 64) begin
			it = random_date(1, LAST_YEAR);
			it.count = CNT_W'($urandom_range(3000));
		end else if (pick < 76) begin
			case ($urandom_range(5))
				0:       y = 1600;
				1:       y = 1900;
				2:       y = 2000;
				3:       y = 2100;
				4:       y = 1;
				default: y = $urandom_range(LAST_YEAR - 1, 1);
			endcase
			it = random_date(y, y);
			len = days_in_month(it.month, y);
			case ($urandom_range(2))
				0:       it.day = DAY_W'(len);
				1:       it.day = DAY_W'(len - 1);
				default: it.day = DAY_W'(1);
			endcase
			it.count = CNT_W'($urandom_range(15));
		end else if (pick < 84) begin
			it = random_date(LAST_YEAR, LAST_YEAR);
			it.count = CNT_W'($urandom);
		end else begin
			it.day = DAY_W'($urandom);
			it.month = MON_W'($urandom);
			it.year = YEAR_W'($urandom);
			it.count = CNT_W'($urandom);
			case ($urandom_range(3))
				0: it.day = '0;
				1: it.month = ($urandom_range(3) == 0) ? '0 : MON_W'($urandom_range(15, 13));
				2: it.year = ($urandom_range(3) == 0) ? '0 :
					YEAR_W'($urandom_range(YEAR_FIELD_MAX, LAST_YEAR + 1));
				default: begin
					y = $urandom_range(LAST_YEAR, 1);
					it.year = YEAR_W'(y);
					it.month = MON_W'(short_mon[$urandom_range(4)]);
					len = days_in_month(it.month, y);
					it.day = DAY_W'($urandom_range(31, len + 1));
				end
			endcase
		end
		return it;
	endfunction

	task automatic send_item(input date_in_t it, input logic typed, input date_out_t typed_want);
		date_out_t want;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, it.count, it.year, it.month, it.day};
		do @(negedge clk); while (!in_taken);
		want = predict_end_date(it);
		if (typed)
			want = typed_want;
		end_date_q.push_back(want);
		items_sent++;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: result %0d %s mismatch, expected %0d, actual %0d",
				$time, results_seen, name, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		date_out_t got;
		date_out_t want;
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got.day = m_tdata[4:0];
			got.month = m_tdata[8:5];
			got.year = m_tdata[22:9];
			got.weekday = m_tdata[25:23];
			got.bad = m_tuser[0];
			got.ovf = m_tuser[1];
			if (end_date_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d wd %0d",
					$time, got.year, got.month, got.day, got.weekday);
				errors++;
			end else begin
				want = end_date_q.pop_front();
				check_field("end_day", want.day, got.day);
				check_field("end_month", want.month, got.month);
				check_field("end_year", want.year, got.year);
				check_field("end_weekday", want.weekday, got.weekday);
				check_field("bad_date", want.bad, got.bad);
				check_field("year_overflow", want.ovf, got.ovf);
			end
			results_seen++;
			if (got.bad)
				bad_seen++;
			if (got.ovf)
				ovf_seen++;
		end
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int src_pct [3];
		int sink_pct [3];
		src_pct = '{38, 51, 0};
		sink_pct = '{51, 38, 0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < DIR_N; i++)
			send_item(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		for (int p = 0; p < 3; p++) begin
			src_idle_pct = src_pct[p];
			sink_idle_pct = sink_pct[p];
			for (int i = 0; i < RAND_PER_PHASE; i++)
				send_item(next_random_item(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		while (end_date_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d dates (%0d directed), %0d results checked",
			items_sent, DIR_N, results_seen);
		$display("  %0d invalid start dates, %0d walks stopped at the last year, %0d errors",
			bad_seen, ovf_seen, errors);
		if (errors == 0 && end_date_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
